>>> src/rsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_pkg: shared types and constants of the stream decoder
// Byte codes, error codes, register indexes and the records that pass
// between the front queue, the parser and the output register.
// ----------------------------------------------------------------------------
package rsd_pkg;

  // field widths fixed by the interface
  localparam int unsigned BULK_CFG_W = 30;
  localparam int unsigned CNT_CFG_W  = 21;
  localparam int unsigned CFG_DW     = 30;
  localparam int unsigned POS_W      = 20;

  // reset values of the limit registers
  localparam logic [BULK_CFG_W-1:0] MAX_BULK_RST  = 30'd536870912;
  localparam logic [CNT_CFG_W-1:0]  MAX_COUNT_RST = 21'd1048576;

  // register indexes
  localparam logic CFG_MAX_BULK  = 1'b0;
  localparam logic CFG_MAX_COUNT = 1'b1;

  // protocol bytes
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_TYPE  = 3'd1,
    ERR_LEN   = 3'd2,
    ERR_FRAME = 3'd3,
    ERR_ELEM  = 3'd4
  } err_e;

  // one classified input byte
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] digit;
    logic       is_digit;
    logic       is_cr;
    logic       is_lf;
    logic       is_plus;
    logic       is_dollar;
    logic       is_star;
    logic       is_minus;
  } tok_t;

  // queue head as seen by the parser
  typedef struct packed {
    logic valid;
    tok_t tok;
  } tok_head_t;

  // one result beat
  typedef struct packed {
    logic [7:0]       data;
    logic             byte_valid;
    logic             elem_end;
    logic             elem_null;
    logic             elem_kind;
    logic             in_array;
    logic [POS_W-1:0] position;
    logic             msg_end;
    err_e             error;
  } res_t;

endpackage

>>> src/rsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_front: byte intake and classification
// Accepts raw bytes, tags each with its character class and holds them in a
// two-entry queue in front of the parser.
// ----------------------------------------------------------------------------
module rsd_front
  import rsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output tok_head_t  head_o,
  input  logic       pop_i
);

  localparam int unsigned Depth = 2;

  tok_t              mem_q [Depth];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;
  tok_t              tok_in;
  logic              push;

  // character class of the incoming byte
  always_comb begin
    tok_in           = '0;
    tok_in.data      = in_byte_i;
    tok_in.is_digit  = in_byte_i inside {[CH_ZERO:CH_NINE]};
    tok_in.digit     = 4'(in_byte_i - CH_ZERO);
    tok_in.is_cr     = (in_byte_i == CH_CR);
    tok_in.is_lf     = (in_byte_i == CH_LF);
    tok_in.is_plus   = (in_byte_i == CH_PLUS);
    tok_in.is_dollar = (in_byte_i == CH_DOLLAR);
    tok_in.is_star   = (in_byte_i == CH_STAR);
    tok_in.is_minus  = (in_byte_i == CH_MINUS);
  end

  assign in_ready_o = (count_q != 2'(Depth));
  assign push       = in_valid_i && in_ready_o;

  // queue pointers
  always_comb begin
    wr_ptr_d = push  ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= tok_in;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.tok   = mem_q[rd_ptr_q];

endmodule

>>> src/rsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_back: message parser and result register
// Walks the message grammar one classified byte per cycle unless the output
// register is full and not taken, and loads at most one result beat into it.
// ----------------------------------------------------------------------------
module rsd_back
  import rsd_pkg::*;
#(
  parameter int unsigned LEN_BITS   = 32,
  parameter int unsigned COUNT_BITS = 21
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [BULK_CFG_W-1:0] max_bulk_i,
  input  logic [CNT_CFG_W-1:0]  max_count_i,
  input  tok_head_t             head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output res_t                  res_o
);

  localparam int unsigned ProdW = LEN_BITS + 4;
  localparam int unsigned MaxA  = (LEN_BITS > BULK_CFG_W) ? LEN_BITS : BULK_CFG_W;
  localparam int unsigned MaxB  = (COUNT_BITS > CNT_CFG_W) ? COUNT_BITS : CNT_CFG_W;
  localparam int unsigned CmpW  = ((MaxA > MaxB) ? MaxA : MaxB) + 1;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_SIMPLE    = 11'b000_0000_0010,
    S_SIMPLE_LF = 11'b000_0000_0100,
    S_BLEN      = 11'b000_0000_1000,
    S_BLEN_LF   = 11'b000_0001_0000,
    S_CNT       = 11'b000_0010_0000,
    S_CNT_LF    = 11'b000_0100_0000,
    S_DATA      = 11'b000_1000_0000,
    S_DATA_CR   = 11'b001_0000_0000,
    S_DATA_LF   = 11'b010_0000_0000,
    S_ETYPE     = 11'b100_0000_0000
  } phase_e;

  phase_e                phase_q, phase_d;
  logic                  arr_q, arr_d;
  logic                  kind_q, kind_d;
  logic [LEN_BITS-1:0]   acc_q, acc_d;
  logic                  neg_q, neg_d;
  logic                  dig_q, dig_d;
  logic [COUNT_BITS-1:0] left_q, left_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic                  out_valid_q;
  res_t                  res_q;

  tok_t                  tok;
  logic                  adv;
  logic                  emit;
  res_t                  res;
  logic                  do_fail, do_finish, do_idle, fin_null;
  err_e                  fail_code;
  logic [ProdW-1:0]      prod;
  logic [LEN_BITS-1:0]   acc_sat, acc_dec;
  logic [CmpW-1:0]       acc_x, bulk_x, cnt_cfg_x, cnt_lim_x;
  logic                  acc_full;
  logic [COUNT_BITS-1:0] left_dec;
  logic [POS_W-1:0]      cur_pos;

  assign tok   = head_i.tok;
  assign adv   = head_i.valid && (!out_valid_q || out_ready_i);
  assign pop_o = adv;

  // decimal accumulate, saturating at all ones
  assign prod     = (ProdW'(acc_q) << 3) + (ProdW'(acc_q) << 1) + ProdW'(tok.digit);
  assign acc_sat  = (prod[ProdW-1:LEN_BITS] != '0) ? '1 : prod[LEN_BITS-1:0];
  assign acc_dec  = acc_q - LEN_BITS'(1);
  assign acc_full = (acc_q == '1);

  // limit compares on a common width
  assign acc_x     = CmpW'(acc_q);
  assign bulk_x    = CmpW'(max_bulk_i);
  assign cnt_cfg_x = CmpW'(max_count_i);
  assign cnt_lim_x = (CmpW'(1) << COUNT_BITS) - CmpW'(1);

  assign left_dec = left_q - COUNT_BITS'(1);
  assign cur_pos  = arr_q ? pos_q : '0;

  // parser next state
  always_comb begin
    phase_d   = phase_q;
    arr_d     = arr_q;
    kind_d    = kind_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    dig_d     = dig_q;
    left_d    = left_q;
    pos_d     = pos_q;
    emit      = 1'b0;
    res       = '0;
    do_fail   = 1'b0;
    do_finish = 1'b0;
    do_idle   = 1'b0;
    fin_null  = 1'b0;
    fail_code = ERR_NONE;

    case (phase_q)
      S_IDLE, S_ETYPE: begin
        if (tok.is_star && phase_q == S_IDLE) begin
          phase_d = S_CNT;
          acc_d   = '0;
          neg_d   = 1'b0;
          dig_d   = 1'b0;
        end else if (tok.is_plus) begin
          kind_d  = 1'b0;
          phase_d = S_SIMPLE;
        end else if (tok.is_dollar) begin
          kind_d  = 1'b1;
          phase_d = S_BLEN;
          acc_d   = '0;
          neg_d   = 1'b0;
          dig_d   = 1'b0;
        end else begin
          do_fail   = 1'b1;
          fail_code = (phase_q == S_IDLE) ? ERR_TYPE : ERR_ELEM;
        end
      end
      S_SIMPLE: begin
        if (tok.is_cr) begin
          phase_d = S_SIMPLE_LF;
        end else if (tok.is_lf) begin
          do_fail   = 1'b1;
          fail_code = ERR_FRAME;
        end else begin
          emit           = 1'b1;
          res.data       = tok.data;
          res.byte_valid = 1'b1;
          res.in_array   = arr_q;
          res.position   = cur_pos;
        end
      end
      S_SIMPLE_LF, S_DATA_LF: begin
        if (!tok.is_lf) begin
          do_fail   = 1'b1;
          fail_code = ERR_FRAME;
        end else begin
          do_finish = 1'b1;
        end
      end
      S_BLEN, S_CNT: begin
        if (tok.is_digit) begin
          acc_d = acc_sat;
          dig_d = 1'b1;
        end else if (tok.is_minus && !dig_q && !neg_q) begin
          neg_d = 1'b1;
        end else if (tok.is_cr && dig_q) begin
          phase_d = (phase_q == S_BLEN) ? S_BLEN_LF : S_CNT_LF;
        end else begin
          do_fail   = 1'b1;
          fail_code = ERR_LEN;
        end
      end
      S_BLEN_LF: begin
        if (!tok.is_lf) begin
          do_fail   = 1'b1;
          fail_code = ERR_FRAME;
        end else if (acc_full) begin
          do_fail   = 1'b1;
          fail_code = ERR_LEN;
        end else if (neg_q) begin
          // only minus one is a legal negative length: the null element
          if (acc_q != LEN_BITS'(1)) begin
            do_fail   = 1'b1;
            fail_code = ERR_LEN;
          end else begin
            do_finish = 1'b1;
            fin_null  = 1'b1;
          end
        end else if (acc_x > bulk_x) begin
          do_fail   = 1'b1;
          fail_code = ERR_LEN;
        end else begin
          phase_d = (acc_q == '0) ? S_DATA_CR : S_DATA;
        end
      end
      S_CNT_LF: begin
        if (!tok.is_lf) begin
          do_fail   = 1'b1;
          fail_code = ERR_FRAME;
        end else if (neg_q || acc_full || (acc_x > cnt_cfg_x) || (acc_x > cnt_lim_x)) begin
          do_fail   = 1'b1;
          fail_code = ERR_LEN;
        end else if (acc_q == '0) begin
          // empty array closes the message at once
          emit         = 1'b1;
          res.in_array = 1'b1;
          res.msg_end  = 1'b1;
          do_idle      = 1'b1;
        end else begin
          arr_d   = 1'b1;
          left_d  = acc_x[COUNT_BITS-1:0];
          pos_d   = '0;
          acc_d   = '0;
          phase_d = S_ETYPE;
        end
      end
      S_DATA: begin
        emit           = 1'b1;
        res.data       = tok.data;
        res.byte_valid = 1'b1;
        res.elem_kind  = 1'b1;
        res.in_array   = arr_q;
        res.position   = cur_pos;
        acc_d          = acc_dec;
        if (acc_dec == '0) begin
          phase_d = S_DATA_CR;
        end
      end
      S_DATA_CR: begin
        if (!tok.is_cr) begin
          do_fail   = 1'b1;
          fail_code = ERR_FRAME;
        end else begin
          phase_d = S_DATA_LF;
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // element close: step the array or end the message
    if (do_finish) begin
      emit          = 1'b1;
      res.elem_end  = 1'b1;
      res.elem_null = fin_null;
      res.elem_kind = kind_q;
      res.in_array  = arr_q;
      res.position  = cur_pos;
      res.msg_end   = 1'b1;
      do_idle       = 1'b1;
      if (arr_q) begin
        left_d = left_dec;
        if (left_dec != '0) begin
          res.msg_end = 1'b0;
          do_idle     = 1'b0;
          pos_d       = pos_q + POS_W'(1);
          phase_d     = S_ETYPE;
        end
      end
    end

    // fault: error beat only
    if (do_fail) begin
      emit      = 1'b1;
      res       = '0;
      res.error = fail_code;
      do_idle   = 1'b1;
    end

    if (do_idle) begin
      phase_d = S_IDLE;
      arr_d   = 1'b0;
      kind_d  = 1'b0;
      acc_d   = '0;
      neg_d   = 1'b0;
      dig_d   = 1'b0;
      left_d  = '0;
      pos_d   = '0;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= S_IDLE;
      arr_q   <= 1'b0;
      kind_q  <= 1'b0;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      dig_q   <= 1'b0;
      left_q  <= '0;
      pos_q   <= '0;
    end else if (adv) begin
      phase_q <= phase_d;
      arr_q   <= arr_d;
      kind_q  <= kind_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      dig_q   <= dig_d;
      left_q  <= left_d;
      pos_q   <= pos_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

>>> src/resp_stream_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resp_stream_decoder_top: byte-serial request message decoder
// Decodes simple strings, bulk strings (with null) and arrays of them from a
// byte stream into payload, element-end, message-end and error beats.
// ----------------------------------------------------------------------------
// The block takes one protocol byte per cycle and gives at most one result
// beat per byte, sustaining one byte per cycle while the result side keeps up.
// An accepted byte enters a two-entry queue; the parser works on the queue
// head and registers its result in the output register, so a byte's result
// reaches the output port through the queue entry and then the output
// register when the result side is ready. The parser's combinational
// next-state step, including the decimal accumulate, sets the rate. Limit
// registers may be written only while no message is in flight.
module resp_stream_decoder_top
  import rsd_pkg::*;
#(
  parameter int unsigned LEN_BITS   = 32,
  parameter int unsigned COUNT_BITS = 21
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              byte_valid_o,
  output logic              elem_end_o,
  output logic              elem_null_o,
  output logic              elem_kind_o,
  output logic              in_array_o,
  output logic [POS_W-1:0]  elem_position_o,
  output logic              msg_end_o,
  output logic [2:0]        error_code_o
);

  logic [BULK_CFG_W-1:0] max_bulk_q;
  logic [CNT_CFG_W-1:0]  max_count_q;
  tok_head_t             head;
  logic                  pop;
  res_t                  res;

  // limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bulk_q  <= MAX_BULK_RST;
      max_count_q <= MAX_COUNT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MAX_BULK) begin
        max_bulk_q <= cfg_data_i[BULK_CFG_W-1:0];
      end
      if (cfg_idx_i == CFG_MAX_COUNT) begin
        max_count_q <= cfg_data_i[CNT_CFG_W-1:0];
      end
    end
  end

  rsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  rsd_back #(
    .LEN_BITS   (LEN_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_bulk_i  (max_bulk_q),
    .max_count_i (max_count_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign out_byte_o      = res.data;
  assign byte_valid_o    = res.byte_valid;
  assign elem_end_o      = res.elem_end;
  assign elem_null_o     = res.elem_null;
  assign elem_kind_o     = res.elem_kind;
  assign in_array_o      = res.in_array;
  assign elem_position_o = res.position;
  assign msg_end_o       = res.msg_end;
  assign error_code_o    = res.error;

  // error beats carry nothing else
  a_err_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != ERR_NONE) |->
      !byte_valid_o && !elem_end_o && !msg_end_o && !in_array_o && (out_byte_o == 8'd0))
    else $error("error beat carries payload or markers");

  // a payload beat never closes an element or a message
  a_byte_no_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> !elem_end_o && !msg_end_o)
    else $error("payload beat flagged as end");

  // null elements are closing bulk elements
  a_null_bulk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && elem_null_o |-> elem_end_o && elem_kind_o)
    else $error("null flag on a non-bulk or non-ending beat");

  // the parser only pops a present queue entry
  a_pop_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("parser popped an empty queue");

endmodule
